### rtl/fltrk_pkg.sv
// Shared types, codes and record update functions for the fault lifecycle tracker.
// No dependencies; every other file imports this package.
`default_nettype none

package fltrk_pkg;

   localparam int TIME_BITS = 32;
   localparam int NFAULT    = 6;
   localparam int IDX_BITS  = 3;

   localparam logic [7:0] COUNT_MAX = 8'hFF;

   localparam logic [3:0] OP_TICK         = 4'd0;
   localparam logic [3:0] OP_COMMIT       = 4'd1;
   localparam logic [3:0] OP_SENSOR_ON    = 4'd2;
   localparam logic [3:0] OP_SENSOR_FAULT = 4'd3;
   localparam logic [3:0] OP_DISPLAY_FAIL = 4'd4;
   localparam logic [3:0] OP_BATTERY      = 4'd5;
   localparam logic [3:0] OP_CKPT_TIMEOUT = 4'd6;
   localparam logic [3:0] OP_TIME_INVALID = 4'd7;
   localparam logic [3:0] OP_WDT_BOOT     = 4'd8;
   localparam logic [3:0] OP_CLEAR        = 4'd9;

   localparam logic [1:0] CAUSE_NONE     = 2'd0;
   localparam logic [1:0] CAUSE_WATCHDOG = 2'd1;
   localparam logic [1:0] CAUSE_STORAGE  = 2'd2;
   localparam logic [1:0] CAUSE_SENSOR   = 2'd3;

   localparam logic [2:0] IDX_STORAGE  = 3'd0;
   localparam logic [2:0] IDX_SENSOR   = 3'd1;
   localparam logic [2:0] IDX_DISPLAY  = 3'd2;
   localparam logic [2:0] IDX_TIME     = 3'd3;
   localparam logic [2:0] IDX_BATTERY  = 3'd4;
   localparam logic [2:0] IDX_WATCHDOG = 3'd5;

   localparam logic [2:0] REG_COOLDOWN_STORAGE = 3'd0;
   localparam logic [2:0] REG_COOLDOWN_SENSOR  = 3'd1;
   localparam logic [2:0] REG_COOLDOWN_MINOR   = 3'd2;
   localparam logic [2:0] REG_HOLDOFF          = 3'd3;
   localparam logic [2:0] REG_SENSOR_THRESHOLD = 3'd4;

   localparam logic [15:0] RST_COOLDOWN_STORAGE = 16'd4000;
   localparam logic [15:0] RST_COOLDOWN_SENSOR  = 16'd5000;
   localparam logic [15:0] RST_COOLDOWN_MINOR   = 16'd2000;
   localparam logic [15:0] RST_HOLDOFF          = 16'd3000;
   localparam logic [7:0]  RST_SENSOR_THRESHOLD = 8'd8;

   typedef enum logic [2:0] {
      LC_NONE      = 3'd0,
      LC_RETRY     = 3'd1,
      LC_DEGRADED  = 3'd2,
      LC_LATCHED   = 3'd3,
      LC_RECOVERED = 3'd4
   } lifecycle_type;

   typedef struct packed {
      logic                 seen;
      logic [7:0]           count;
      logic [7:0]           recoveries;
      lifecycle_type        stage;
      logic [TIME_BITS-1:0] deadline;
      logic                 blocks;
   } rec_type;

   typedef struct packed {
      logic [3:0]           opcode;
      logic [TIME_BITS-1:0] now_ms;
      logic                 commit_ok;
      logic                 reason_idle;
      logic [7:0]           sensor_fault_count;
      logic [2:0]           query_code;
   } req_item_type;

   typedef struct packed {
      logic       safe_mode_on;
      logic [1:0] safe_mode_cause;
      logic       clear_allowed;
      logic       any_blocking;
      logic [2:0] last_fault;
      logic [2:0] query_lifecycle;
      logic [7:0] query_count;
      logic [7:0] query_recoveries;
      logic       query_blocking;
   } rsp_item_type;

   function automatic logic [7:0] sat_inc(input logic [7:0] value);
      return (value != COUNT_MAX) ? value + 8'd1 : value;
   endfunction

   function automatic logic [7:0] budget_of(input logic [IDX_BITS-1:0] idx);
      logic [7:0] budget;
      unique case (idx)
         IDX_STORAGE: budget = 8'd2;
         IDX_SENSOR:  budget = 8'd3;
         IDX_DISPLAY, IDX_TIME, IDX_BATTERY: budget = 8'd1;
         default:     budget = 8'd0;
      endcase
      return budget;
   endfunction

   function automatic rec_type note_rec(input rec_type r, input logic [IDX_BITS-1:0] idx,
                                        input logic [TIME_BITS-1:0] now,
                                        input logic [TIME_BITS-1:0] cd);
      rec_type    n;
      logic [7:0] budget;
      n      = r;
      budget = budget_of(idx);
      if (!n.seen) begin
         n.count      = '0;
         n.recoveries = '0;
         n.seen       = 1'b1;
      end
      n.deadline = now + cd;
      n.count    = sat_inc(n.count);
      if (idx == IDX_WATCHDOG) begin
         n.stage = LC_LATCHED;
      end else if (budget != 8'd0 && n.count < budget) begin
         n.stage = LC_RETRY;
      end else begin
         n.stage = LC_DEGRADED;
      end
      n.blocks = 1'b1;
      return n;
   endfunction

   function automatic rec_type mark_rec(input rec_type r, input logic [TIME_BITS-1:0] now,
                                        input logic [TIME_BITS-1:0] cd);
      rec_type n;
      n = r;
      if (n.seen) begin
         n.stage      = LC_RECOVERED;
         n.deadline   = now + cd;
         n.blocks     = (cd != '0);
         n.recoveries = sat_inc(n.recoveries);
      end
      return n;
   endfunction

endpackage

`default_nettype wire

### rtl/fltrk_if.sv
// Valid/ready channel interfaces for event requests, responses and register writes.
// Depends on fltrk_pkg for the time width.
`default_nettype none

interface fltrk_req_if
   import fltrk_pkg::*;
   ;
   logic                 valid;
   logic                 ready;
   logic [3:0]           opcode;
   logic [TIME_BITS-1:0] now_ms;
   logic                 commit_ok;
   logic                 reason_idle;
   logic [7:0]           sensor_fault_count;
   logic [2:0]           query_code;

   modport source (output valid, opcode, now_ms, commit_ok, reason_idle,
                   sensor_fault_count, query_code, input ready);
   modport sink   (input valid, opcode, now_ms, commit_ok, reason_idle,
                   sensor_fault_count, query_code, output ready);
endinterface

interface fltrk_rsp_if;
   logic       valid;
   logic       ready;
   logic       safe_mode_on;
   logic [1:0] safe_mode_cause;
   logic       clear_allowed;
   logic       any_blocking;
   logic [2:0] last_fault;
   logic [2:0] query_lifecycle;
   logic [7:0] query_count;
   logic [7:0] query_recoveries;
   logic       query_blocking;

   modport source (output valid, safe_mode_on, safe_mode_cause, clear_allowed, any_blocking,
                   last_fault, query_lifecycle, query_count, query_recoveries,
                   query_blocking, input ready);
   modport sink   (input valid, safe_mode_on, safe_mode_cause, clear_allowed, any_blocking,
                   last_fault, query_lifecycle, query_count, query_recoveries,
                   query_blocking, output ready);
endinterface

interface fltrk_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/fault_lifecycle_safe_mode_tracker_top.sv
// Fault lifecycle and safe-mode tracker: six fault records and a safe-mode latch.
// A request transfer is captured in the input register, then its response in the response
// register; one event per cycle is sustained while rsp is ready, bounded by the single
// record-update pass between the two registers. Backpressure on rsp stalls req.
// Reset (synchronous, active high) clears all records, the latch and loads register defaults.
// Depends on fltrk_pkg and fltrk_if.
`default_nettype none

module fault_lifecycle_safe_mode_tracker_top
   import fltrk_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   fltrk_req_if.sink   req_chan,
   fltrk_rsp_if.source rsp_chan,
   fltrk_csr_if.sink   csr_chan
);

   logic [15:0] cd_storage_ff, cd_sensor_ff, cd_minor_ff, holdoff_ff;
   logic [7:0]  threshold_ff;

   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         out_valid_ff;
   rsp_item_type out_item_ff;
   rsp_item_type out_item_in;
   logic         advance;

   rec_type              rec_ff [NFAULT];
   rec_type              rec_in [NFAULT];
   logic                 safe_active_ff, safe_active_in;
   logic [1:0]           safe_reason_ff, safe_reason_in;
   logic [TIME_BITS-1:0] safe_since_ff, safe_since_in;
   logic                 clear_ok_ff, clear_ok_in;
   logic [2:0]           last_code_ff, last_code_in;

   function automatic logic [TIME_BITS-1:0] cooldown_of(input logic [IDX_BITS-1:0] idx);
      logic [15:0] cd;
      unique case (idx)
         IDX_STORAGE:  cd = cd_storage_ff;
         IDX_SENSOR:   cd = cd_sensor_ff;
         IDX_DISPLAY, IDX_TIME, IDX_BATTERY: cd = cd_minor_ff;
         IDX_WATCHDOG: cd = holdoff_ff;
         default:      cd = '0;
      endcase
      return TIME_BITS'(cd);
   endfunction

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cd_storage_ff <= RST_COOLDOWN_STORAGE;
         cd_sensor_ff  <= RST_COOLDOWN_SENSOR;
         cd_minor_ff   <= RST_COOLDOWN_MINOR;
         holdoff_ff    <= RST_HOLDOFF;
         threshold_ff  <= RST_SENSOR_THRESHOLD;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_COOLDOWN_STORAGE: cd_storage_ff <= csr_chan.data;
            REG_COOLDOWN_SENSOR:  cd_sensor_ff  <= csr_chan.data;
            REG_COOLDOWN_MINOR:   cd_minor_ff   <= csr_chan.data;
            REG_HOLDOFF:          holdoff_ff    <= csr_chan.data;
            REG_SENSOR_THRESHOLD: threshold_ff  <= csr_chan.data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
      if (req_chan.valid && req_chan.ready) begin
         in_item_ff.opcode             <= req_chan.opcode;
         in_item_ff.now_ms             <= req_chan.now_ms;
         in_item_ff.commit_ok          <= req_chan.commit_ok;
         in_item_ff.reason_idle        <= req_chan.reason_idle;
         in_item_ff.sensor_fault_count <= req_chan.sensor_fault_count;
         in_item_ff.query_code         <= req_chan.query_code;
      end
   end

   always_comb begin
      rec_type              tick_rec [NFAULT];
      rec_type              r;
      logic                 blk_prefix;
      logic                 early;
      logic                 b;
      logic [TIME_BITS-1:0] now;
      logic [TIME_BITS-1:0] cd;
      logic                 note_en, mark_en, safe_en;
      logic [IDX_BITS-1:0]  note_idx, mark_idx, q_idx;
      logic [1:0]           safe_cause;
      logic                 q_ok;
      logic                 any_blk;

      now = in_item_ff.now_ms;

      blk_prefix = 1'b0;
      for (int k = 0; k < NFAULT; k++) begin
         r     = rec_ff[k];
         cd    = cooldown_of(IDX_BITS'(k));
         early = now < r.deadline;
         if (r.seen && r.stage != LC_RECOVERED && k >= int'(IDX_DISPLAY)
             && k <= int'(IDX_BATTERY) && now >= r.deadline) begin
            r.stage      = LC_RECOVERED;
            r.deadline   = now + cd;
            r.recoveries = sat_inc(r.recoveries);
            early        = now < r.deadline;
         end
         if (!r.seen) begin
            b = 1'b0;
         end else if (r.stage == LC_RECOVERED || k == int'(IDX_WATCHDOG)) begin
            b = early;
         end else begin
            b = early || r.stage == LC_LATCHED;
         end
         r.blocks    = b;
         tick_rec[k] = blk_prefix ? rec_ff[k] : r;
         blk_prefix  = blk_prefix || b;
      end

      for (int k = 0; k < NFAULT; k++) begin
         rec_in[k] = rec_ff[k];
      end
      safe_active_in = safe_active_ff;
      safe_reason_in = safe_reason_ff;
      safe_since_in  = safe_since_ff;
      clear_ok_in    = clear_ok_ff;
      last_code_in   = last_code_ff;

      note_en    = 1'b0;
      note_idx   = IDX_STORAGE;
      mark_en    = 1'b0;
      mark_idx   = IDX_STORAGE;
      safe_en    = 1'b0;
      safe_cause = CAUSE_NONE;

      unique case (in_item_ff.opcode)
         OP_TICK: begin
            for (int k = 0; k < NFAULT; k++) begin
               rec_in[k] = tick_rec[k];
            end
            clear_ok_in = safe_active_ff && !blk_prefix
                          && ((now - safe_since_ff) >= TIME_BITS'(holdoff_ff));
         end
         OP_COMMIT: begin
            if (!in_item_ff.commit_ok) begin
               note_en    = 1'b1;
               note_idx   = IDX_STORAGE;
               safe_en    = !in_item_ff.reason_idle;
               safe_cause = CAUSE_STORAGE;
            end else begin
               mark_en  = 1'b1;
               mark_idx = IDX_STORAGE;
            end
         end
         OP_SENSOR_ON: begin
            mark_en  = 1'b1;
            mark_idx = IDX_SENSOR;
         end
         OP_SENSOR_FAULT: begin
            note_en    = 1'b1;
            note_idx   = IDX_SENSOR;
            safe_en    = in_item_ff.sensor_fault_count >= threshold_ff;
            safe_cause = CAUSE_SENSOR;
         end
         OP_DISPLAY_FAIL: begin
            note_en  = 1'b1;
            note_idx = IDX_DISPLAY;
         end
         OP_BATTERY: begin
            note_en  = 1'b1;
            note_idx = IDX_BATTERY;
         end
         OP_CKPT_TIMEOUT: begin
            note_en  = 1'b1;
            note_idx = IDX_WATCHDOG;
         end
         OP_TIME_INVALID: begin
            note_en  = 1'b1;
            note_idx = IDX_TIME;
         end
         OP_WDT_BOOT: begin
            note_en    = 1'b1;
            note_idx   = IDX_WATCHDOG;
            safe_en    = 1'b1;
            safe_cause = CAUSE_WATCHDOG;
         end
         OP_CLEAR: begin
            if (safe_active_ff && clear_ok_ff) begin
               safe_active_in = 1'b0;
               clear_ok_in    = 1'b0;
               safe_since_in  = '0;
               safe_reason_in = CAUSE_NONE;
            end
         end
         default: ;
      endcase

      if (note_en) begin
         rec_in[note_idx] = note_rec(rec_ff[note_idx], note_idx, now, cooldown_of(note_idx));
         last_code_in     = note_idx + 3'd1;
         clear_ok_in      = 1'b0;
      end
      if (mark_en) begin
         rec_in[mark_idx] = mark_rec(rec_ff[mark_idx], now, cooldown_of(mark_idx));
      end
      // the noted record is always seen by now, so the cause record latches
      if (safe_en) begin
         if (!safe_active_ff) begin
            safe_since_in = now;
         end
         safe_active_in         = 1'b1;
         clear_ok_in            = 1'b0;
         safe_reason_in         = safe_cause;
         rec_in[note_idx].stage = LC_LATCHED;
      end

      any_blk = 1'b0;
      for (int k = 0; k < NFAULT; k++) begin
         any_blk = any_blk || rec_in[k].blocks;
      end

      q_ok  = in_item_ff.query_code != 3'd0 && in_item_ff.query_code != 3'd7;
      q_idx = q_ok ? in_item_ff.query_code - 3'd1 : IDX_STORAGE;

      out_item_in.safe_mode_on    = safe_active_in;
      out_item_in.safe_mode_cause = safe_reason_in;
      out_item_in.clear_allowed   = clear_ok_in;
      out_item_in.any_blocking    = any_blk;
      out_item_in.last_fault      = last_code_in;
      if (q_ok) begin
         out_item_in.query_lifecycle  = rec_in[q_idx].stage;
         out_item_in.query_count      = rec_in[q_idx].count;
         out_item_in.query_recoveries = rec_in[q_idx].recoveries;
         out_item_in.query_blocking   = rec_in[q_idx].blocks;
      end else begin
         out_item_in.query_lifecycle  = 3'd0;
         out_item_in.query_count      = 8'd0;
         out_item_in.query_recoveries = 8'd0;
         out_item_in.query_blocking   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NFAULT; k++) begin
            rec_ff[k] <= '0;
         end
         safe_active_ff <= 1'b0;
         safe_reason_ff <= CAUSE_NONE;
         safe_since_ff  <= '0;
         clear_ok_ff    <= 1'b0;
         last_code_ff   <= '0;
      end else if (advance) begin
         for (int k = 0; k < NFAULT; k++) begin
            rec_ff[k] <= rec_in[k];
         end
         safe_active_ff <= safe_active_in;
         safe_reason_ff <= safe_reason_in;
         safe_since_ff  <= safe_since_in;
         clear_ok_ff    <= clear_ok_in;
         last_code_ff   <= last_code_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) begin
         out_item_ff <= out_item_in;
      end
   end

   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.safe_mode_on     = out_item_ff.safe_mode_on;
   assign rsp_chan.safe_mode_cause  = out_item_ff.safe_mode_cause;
   assign rsp_chan.clear_allowed    = out_item_ff.clear_allowed;
   assign rsp_chan.any_blocking     = out_item_ff.any_blocking;
   assign rsp_chan.last_fault       = out_item_ff.last_fault;
   assign rsp_chan.query_lifecycle  = out_item_ff.query_lifecycle;
   assign rsp_chan.query_count      = out_item_ff.query_count;
   assign rsp_chan.query_recoveries = out_item_ff.query_recoveries;
   assign rsp_chan.query_blocking   = out_item_ff.query_blocking;

   a_reason_tracks_latch: assert property (@(posedge clock) disable iff (reset)
      safe_active_ff == (safe_reason_ff != CAUSE_NONE))
      else $error("safe-mode reason out of step with latch");

   a_clear_needs_latch: assert property (@(posedge clock) disable iff (reset)
      clear_ok_ff |-> safe_active_ff)
      else $error("clear allowed without safe mode");

   a_watchdog_latched: assert property (@(posedge clock) disable iff (reset)
      rec_ff[IDX_WATCHDOG].seen |-> rec_ff[IDX_WATCHDOG].stage == LC_LATCHED)
      else $error("watchdog record left latched stage");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_item_ff))
      else $error("stalled event lost from input register");

endmodule

`default_nettype wire

### sim/fltrk_outcome_checker.sv
// Outcome checker for the fault lifecycle tracker: watches the request, response and
// register write channels, predicts each response and compares it field by field.
// Depends on fltrk_pkg and the channel interfaces in fltrk_if.
`default_nettype none

module fltrk_outcome_checker
   import fltrk_pkg::*;
(
   input  wire   clock,
   input  wire   reset,
   fltrk_req_if  req_mon,
   fltrk_rsp_if  rsp_mon,
   fltrk_csr_if  csr_mon,
   output int    fail_count,
   output int    pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [15:0]          cd_storage;
   logic [15:0]          cd_sensor;
   logic [15:0]          cd_minor;
   logic [15:0]          holdoff;
   logic [7:0]           sensor_thr;

   logic                 seen     [NFAULT];
   logic [7:0]           count    [NFAULT];
   logic [7:0]           recov    [NFAULT];
   lifecycle_type        stage    [NFAULT];
   logic [TIME_BITS-1:0] deadline [NFAULT];
   logic                 blocks   [NFAULT];

   logic                 safe_on;
   logic [1:0]           safe_cause;
   logic [TIME_BITS-1:0] safe_start;
   logic                 clear_ok;
   logic [2:0]           last_code;

   rsp_item_type         status_q[$];
   int                   errors = 0;

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   function automatic logic [TIME_BITS-1:0] cooldown_for(input logic [2:0] k);
      logic [TIME_BITS-1:0] cd;
      case (k)
         IDX_STORAGE:                        cd = TIME_BITS'(cd_storage);
         IDX_SENSOR:                         cd = TIME_BITS'(cd_sensor);
         IDX_DISPLAY, IDX_TIME, IDX_BATTERY: cd = TIME_BITS'(cd_minor);
         IDX_WATCHDOG:                       cd = TIME_BITS'(holdoff);
         default:                            cd = '0;
      endcase
      return cd;
   endfunction

   function automatic logic [7:0] budget_for(input logic [2:0] k);
      logic [7:0] b;
      case (k)
         IDX_STORAGE:                        b = 8'd2;
         IDX_SENSOR:                         b = 8'd3;
         IDX_DISPLAY, IDX_TIME, IDX_BATTERY: b = 8'd1;
         default:                            b = 8'd0;
      endcase
      return b;
   endfunction

   task automatic clear_state();
      cd_storage = RST_COOLDOWN_STORAGE;
      cd_sensor  = RST_COOLDOWN_SENSOR;
      cd_minor   = RST_COOLDOWN_MINOR;
      holdoff    = RST_HOLDOFF;
      sensor_thr = RST_SENSOR_THRESHOLD;
      for (int k = 0; k < NFAULT; k++) begin
         seen[k]     = 1'b0;
         count[k]    = '0;
         recov[k]    = '0;
         stage[k]    = LC_NONE;
         deadline[k] = '0;
         blocks[k]   = 1'b0;
      end
      safe_on    = 1'b0;
      safe_cause = CAUSE_NONE;
      safe_start = '0;
      clear_ok   = 1'b0;
      last_code  = '0;
   endtask

   task automatic note_fault(input logic [2:0] k, input logic [TIME_BITS-1:0] t);
      if (!seen[k]) begin
         count[k] = '0;
         recov[k] = '0;
         seen[k]  = 1'b1;
      end
      deadline[k] = t + cooldown_for(k);
      if (count[k] != COUNT_MAX) count[k] = count[k] + 8'd1;
      if (k == IDX_WATCHDOG) begin
         stage[k] = LC_LATCHED;
      end else if (budget_for(k) != 8'd0 && count[k] < budget_for(k)) begin
         stage[k] = LC_RETRY;
      end else begin
         stage[k] = LC_DEGRADED;
      end
      blocks[k] = 1'b1;
      last_code = k + 3'd1;
      clear_ok  = 1'b0;
   endtask

   task automatic recover(input logic [2:0] k, input logic [TIME_BITS-1:0] t);
      if (seen[k]) begin
         stage[k]    = LC_RECOVERED;
         deadline[k] = t + cooldown_for(k);
         blocks[k]   = (cooldown_for(k) != '0);
         if (recov[k] != COUNT_MAX) recov[k] = recov[k] + 8'd1;
      end
   endtask

   task automatic enter_safe(input logic [1:0] cause, input logic [2:0] k,
                             input logic [TIME_BITS-1:0] t);
      if (!safe_on) safe_start = t;
      safe_on    = 1'b1;
      clear_ok   = 1'b0;
      safe_cause = cause;
      if (seen[k]) stage[k] = LC_LATCHED;
   endtask

   function automatic logic still_blocking(input logic [2:0] k, input logic [TIME_BITS-1:0] t);
      logic early;
      early = (t < deadline[k]);
      if (!seen[k]) return 1'b0;
      if (stage[k] == LC_RECOVERED || k == IDX_WATCHDOG) return early;
      return early || (stage[k] == LC_LATCHED);
   endfunction

   task automatic scan_records(input logic [TIME_BITS-1:0] t);
      logic hit;
      hit = 1'b0;
      for (int k = 0; k < NFAULT && !hit; k++) begin
         if (seen[k] && stage[k] != LC_RECOVERED && k >= IDX_DISPLAY && k <= IDX_BATTERY &&
             t >= deadline[k])
            recover(3'(k), t);
         blocks[k] = still_blocking(3'(k), t);
         if (blocks[k]) hit = 1'b1;
      end
      if (!safe_on) begin
         clear_ok = 1'b0;
      end else begin
         clear_ok = !hit && ((t - safe_start) >= TIME_BITS'(holdoff));
      end
   endtask

   task automatic apply_event(input req_item_type ev, output rsp_item_type r);
      logic [2:0] k;
      case (ev.opcode)
         OP_TICK: scan_records(ev.now_ms);
         OP_COMMIT: begin
            if (!ev.commit_ok) begin
               note_fault(IDX_STORAGE, ev.now_ms);
               if (!ev.reason_idle) enter_safe(CAUSE_STORAGE, IDX_STORAGE, ev.now_ms);
            end else begin
               recover(IDX_STORAGE, ev.now_ms);
            end
         end
         OP_SENSOR_ON: recover(IDX_SENSOR, ev.now_ms);
         OP_SENSOR_FAULT: begin
            note_fault(IDX_SENSOR, ev.now_ms);
            if (ev.sensor_fault_count >= sensor_thr)
               enter_safe(CAUSE_SENSOR, IDX_SENSOR, ev.now_ms);
         end
         OP_DISPLAY_FAIL: note_fault(IDX_DISPLAY, ev.now_ms);
         OP_BATTERY:      note_fault(IDX_BATTERY, ev.now_ms);
         OP_CKPT_TIMEOUT: note_fault(IDX_WATCHDOG, ev.now_ms);
         OP_TIME_INVALID: note_fault(IDX_TIME, ev.now_ms);
         OP_WDT_BOOT: begin
            note_fault(IDX_WATCHDOG, ev.now_ms);
            enter_safe(CAUSE_WATCHDOG, IDX_WATCHDOG, ev.now_ms);
         end
         OP_CLEAR: begin
            if (safe_on && clear_ok) begin
               safe_on    = 1'b0;
               clear_ok   = 1'b0;
               safe_start = '0;
               safe_cause = CAUSE_NONE;
            end
         end
         default: ;
      endcase
      r = '0;
      r.safe_mode_on    = safe_on;
      r.safe_mode_cause = safe_cause;
      r.clear_allowed   = clear_ok;
      r.last_fault      = last_code;
      for (int i = 0; i < NFAULT; i++) r.any_blocking = r.any_blocking | blocks[i];
      if (ev.query_code != 3'd0 && ev.query_code <= NFAULT) begin
         k                  = ev.query_code - 3'd1;
         r.query_lifecycle  = stage[k];
         r.query_count      = count[k];
         r.query_recoveries = recov[k];
         r.query_blocking   = blocks[k];
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      rsp_item_type got;
      req_item_type ev;
      if (reset) begin
         clear_state();
         status_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.safe_mode_on     = rsp_mon.safe_mode_on;
            got.safe_mode_cause  = rsp_mon.safe_mode_cause;
            got.clear_allowed    = rsp_mon.clear_allowed;
            got.any_blocking     = rsp_mon.any_blocking;
            got.last_fault       = rsp_mon.last_fault;
            got.query_lifecycle  = rsp_mon.query_lifecycle;
            got.query_count      = rsp_mon.query_count;
            got.query_recoveries = rsp_mon.query_recoveries;
            got.query_blocking   = rsp_mon.query_blocking;
            if (status_q.size() == 0) begin
               $error("response transfer with no event outstanding");
               errors++;
            end else begin
               want = status_q.pop_front();
               check_field("safe_mode_on", 32'(want.safe_mode_on),
                           32'(got.safe_mode_on));
               check_field("safe_mode_cause", 32'(want.safe_mode_cause),
                           32'(got.safe_mode_cause));
               check_field("clear_allowed", 32'(want.clear_allowed),
                           32'(got.clear_allowed));
               check_field("any_blocking", 32'(want.any_blocking),
                           32'(got.any_blocking));
               check_field("last_fault", 32'(want.last_fault),
                           32'(got.last_fault));
               check_field("query_lifecycle", 32'(want.query_lifecycle),
                           32'(got.query_lifecycle));
               check_field("query_count", 32'(want.query_count),
                           32'(got.query_count));
               check_field("query_recoveries", 32'(want.query_recoveries),
                           32'(got.query_recoveries));
               check_field("query_blocking", 32'(want.query_blocking),
                           32'(got.query_blocking));
            end
         end
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               REG_COOLDOWN_STORAGE: cd_storage = csr_mon.data;
               REG_COOLDOWN_SENSOR:  cd_sensor  = csr_mon.data;
               REG_COOLDOWN_MINOR:   cd_minor   = csr_mon.data;
               REG_HOLDOFF:          holdoff    = csr_mon.data;
               REG_SENSOR_THRESHOLD: sensor_thr = csr_mon.data[7:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            ev.opcode             = req_mon.opcode;
            ev.now_ms             = req_mon.now_ms;
            ev.commit_ok          = req_mon.commit_ok;
            ev.reason_idle        = req_mon.reason_idle;
            ev.sensor_fault_count = req_mon.sensor_fault_count;
            ev.query_code         = req_mon.query_code;
            apply_event(ev, want);
            status_q.push_back(want);
         end
      end
      fail_count    <= errors;
      pending_count <= status_q.size();
   end

endmodule

`default_nettype wire

### sim/fault_lifecycle_safe_mode_tracker_top_tb.sv
// Testbench top for the fault lifecycle tracker: clock, reset, event stimulus under
// several register settings and idle patterns, and the verdict.
// Depends on fltrk_pkg, fltrk_if, the tracker RTL and fltrk_outcome_checker.
`default_nettype none

module fault_lifecycle_safe_mode_tracker_top_tb
   import fltrk_pkg::*;
   ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;

   logic                 clock;
   logic                 reset;
   int                   fail_count;
   int                   pending_count;
   int                   send_idle_pct = 0;
   int                   stall_pct = 0;
   int                   cycle_count;
   int                   sent_items = 0;
   logic [TIME_BITS-1:0] now_t;
   logic [7:0]           cur_thr;

   fltrk_req_if req_chan ();
   fltrk_rsp_if rsp_chan ();
   fltrk_csr_if csr_chan ();

   fault_lifecycle_safe_mode_tracker_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   fltrk_outcome_checker outcome_chk (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .csr_mon       (csr_chan),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("fault_lifecycle_safe_mode_tracker_top verification failed");
      $finish;
   end

   task automatic send_event(input logic [3:0] op, input logic [TIME_BITS-1:0] t,
                             input logic ok, input logic idle, input logic [7:0] sfc,
                             input logic [2:0] q);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid              <= 1'b1;
      req_chan.opcode             <= op;
      req_chan.now_ms             <= t;
      req_chan.commit_ok          <= ok;
      req_chan.reason_idle        <= idle;
      req_chan.sensor_fault_count <= sfc;
      req_chan.query_code         <= q;
      do @(posedge clock); while (!req_chan.ready);
      sent_items++;
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= val;
      do @(posedge clock); while (!csr_chan.ready);
   endtask

   task automatic set_timing(input logic [15:0] cs, input logic [15:0] cse,
                             input logic [15:0] cm, input logic [15:0] ho,
                             input logic [15:0] thr);
      drain();
      write_reg(REG_COOLDOWN_STORAGE, cs);
      write_reg(REG_COOLDOWN_SENSOR, cse);
      write_reg(REG_COOLDOWN_MINOR, cm);
      write_reg(REG_HOLDOFF, ho);
      write_reg(REG_SENSOR_THRESHOLD, thr);
      csr_chan.valid <= 1'b0;
      cur_thr = thr[7:0];
   endtask

   function automatic logic [TIME_BITS-1:0] later(input logic [TIME_BITS-1:0] t);
      int pick;
      pick = $urandom_range(99);
      if (pick < 65) return t + $urandom_range(0, 1500);
      if (pick < 88) return t + $urandom_range(0, 8000);
      if (pick < 97) return t + $urandom_range(0, 70000);
      return $urandom;
   endfunction

   function automatic logic [2:0] pick_query();
      if ($urandom_range(9) == 0) return $urandom_range(1) ? 3'd7 : 3'd0;
      return 3'($urandom_range(1, 6));
   endfunction

   function automatic logic [7:0] pick_sfc();
      case ($urandom_range(5))
         0:       return cur_thr;
         1:       return cur_thr - 8'd1;
         2:       return 8'd0;
         3:       return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic logic rnd_bit();
      return 1'($urandom_range(1));
   endfunction

   function automatic logic [7:0] rnd_byte();
      return 8'($urandom);
   endfunction

   function automatic logic [15:0] rnd_cd();
      return 16'($urandom_range(0, 3000));
   endfunction

   task automatic incident();
      int n;
      int m;
      int pick;
      n = $urandom_range(1, 3);
      repeat (n) begin
         now_t = now_t + $urandom_range(0, 500);
         case ($urandom_range(6))
            0: send_event(OP_COMMIT, now_t, 1'b0, rnd_bit(), rnd_byte(), pick_query());
            1: send_event(OP_SENSOR_FAULT, now_t, rnd_bit(), rnd_bit(),
                          pick_sfc(), pick_query());
            2: send_event(OP_DISPLAY_FAIL, now_t, rnd_bit(), rnd_bit(),
                          rnd_byte(), pick_query());
            3: send_event(OP_BATTERY, now_t, rnd_bit(), rnd_bit(),
                          rnd_byte(), pick_query());
            4: send_event(OP_CKPT_TIMEOUT, now_t, rnd_bit(), rnd_bit(),
                          rnd_byte(), pick_query());
            5: send_event(OP_TIME_INVALID, now_t, rnd_bit(), rnd_bit(),
                          rnd_byte(), pick_query());
            default: send_event(OP_WDT_BOOT, now_t, rnd_bit(), rnd_bit(),
                                rnd_byte(), pick_query());
         endcase
      end
      m = $urandom_range(2, 8);
      repeat (m) begin
         now_t = later(now_t);
         pick  = $urandom_range(19);
         if (pick < 13) begin
            send_event(OP_TICK, now_t, rnd_bit(), rnd_bit(), rnd_byte(),
                       pick_query());
         end else if (pick < 15) begin
            send_event(OP_COMMIT, now_t, 1'b1, rnd_bit(), rnd_byte(), pick_query());
         end else if (pick < 17) begin
            send_event(OP_SENSOR_ON, now_t, rnd_bit(), rnd_bit(), rnd_byte(),
                       pick_query());
         end else begin
            send_event(OP_CLEAR, now_t, rnd_bit(), rnd_bit(), rnd_byte(),
                       pick_query());
         end
      end
      send_event(OP_CLEAR, now_t, rnd_bit(), rnd_bit(), rnd_byte(), pick_query());
   endtask

   task automatic noise();
      now_t = ($urandom_range(3) == 0) ? TIME_BITS'($urandom) : later(now_t);
      send_event(4'($urandom_range(15)), now_t, rnd_bit(), rnd_bit(), rnd_byte(),
                 3'($urandom_range(7)));
   endtask

   task automatic storage_saturation();
      repeat (256) begin
         now_t = now_t + $urandom_range(0, 200);
         send_event(OP_COMMIT, now_t, 1'b0, rnd_bit(), rnd_byte(), pick_query());
         now_t = now_t + $urandom_range(0, 200);
         send_event(OP_COMMIT, now_t, 1'b1, rnd_bit(), rnd_byte(), pick_query());
      end
   endtask

   initial begin
      int phase_end;
      reset                       = 1'b1;
      req_chan.valid              = 1'b0;
      req_chan.opcode             = OP_TICK;
      req_chan.now_ms             = '0;
      req_chan.commit_ok          = 1'b0;
      req_chan.reason_idle        = 1'b0;
      req_chan.sensor_fault_count = '0;
      req_chan.query_code         = '0;
      csr_chan.valid              = 1'b0;
      csr_chan.index              = REG_COOLDOWN_STORAGE;
      csr_chan.data               = '0;
      now_t                       = '0;
      cur_thr                     = RST_SENSOR_THRESHOLD;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_event(OP_TICK, 32'd0, 1'b0, 1'b0, 8'd0, 3'd1);
      send_event(4'd15, 32'd0, 1'b1, 1'b1, 8'hFF, 3'd7);
      send_event(OP_CLEAR, 32'd5, 1'b0, 1'b0, 8'd0, 3'd0);
      send_event(OP_SENSOR_ON, 32'd10, 1'b0, 1'b0, 8'd0, 3'd2);
      send_event(OP_COMMIT, 32'd20, 1'b1, 1'b0, 8'd0, 3'd1);
      send_event(OP_COMMIT, 32'd100, 1'b0, 1'b1, 8'd0, 3'd1);
      send_event(OP_COMMIT, 32'd200, 1'b0, 1'b0, 8'd0, 3'd1);
      send_event(OP_SENSOR_FAULT, 32'd300, 1'b0, 1'b0, 8'd0, 3'd2);
      send_event(OP_SENSOR_FAULT, 32'd400, 1'b0, 1'b0, 8'hFF, 3'd2);
      send_event(OP_DISPLAY_FAIL, 32'd500, 1'b0, 1'b0, 8'd0, 3'd3);
      send_event(OP_TIME_INVALID, 32'd600, 1'b0, 1'b0, 8'd0, 3'd4);
      send_event(OP_BATTERY, 32'd700, 1'b0, 1'b0, 8'd0, 3'd5);
      send_event(OP_CKPT_TIMEOUT, 32'd800, 1'b0, 1'b0, 8'd0, 3'd6);
      send_event(OP_TICK, 32'd1000, 1'b0, 1'b0, 8'd0, 3'd3);
      send_event(OP_COMMIT, 32'd2000, 1'b1, 1'b0, 8'd0, 3'd1);
      send_event(OP_SENSOR_ON, 32'd2100, 1'b0, 1'b0, 8'd0, 3'd2);
      send_event(OP_WDT_BOOT, 32'hFFFF_FF00, 1'b0, 1'b0, 8'd0, 3'd6);
      send_event(OP_TICK, 32'hFFFF_FFFF, 1'b0, 1'b0, 8'd0, 3'd4);
      send_event(OP_CLEAR, 32'hFFFF_FFFF, 1'b0, 1'b0, 8'd0, 3'd6);
      send_event(OP_TICK, 32'h0010_0000, 1'b0, 1'b0, 8'd0, 3'd5);
      send_event(OP_CLEAR, 32'h0010_0000, 1'b0, 1'b0, 8'd0, 3'd3);
      send_event(OP_TICK, 32'h0020_0000, 1'b0, 1'b0, 8'd0, 3'd0);
      send_event(OP_CLEAR, 32'h0020_0000, 1'b0, 1'b0, 8'd0, 3'd1);
      now_t = 32'h0020_0000;

      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: set_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
            1: set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h00FF);
            2, 6: set_timing(rnd_cd(), rnd_cd(), rnd_cd(), rnd_cd(),
                             {8'($urandom), 8'($urandom_range(0, 12))});
            3: set_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
            5: set_timing(RST_COOLDOWN_STORAGE, RST_COOLDOWN_SENSOR, RST_COOLDOWN_MINOR,
                          RST_HOLDOFF, {8'd0, RST_SENSOR_THRESHOLD});
            default: set_timing(16'($urandom), 16'($urandom), 16'($urandom),
                                16'($urandom), 16'($urandom));
         endcase
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 65; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 65; end
            default: begin send_idle_pct = 16; stall_pct = 16; end
         endcase
         if (ph == 5) storage_saturation();
         phase_end = sent_items + 100;
         while (sent_items < phase_end) begin
            if ($urandom_range(4) == 0) noise();
            else incident();
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("fault_lifecycle_safe_mode_tracker_top verification clean");
      end else begin
         $display("fault_lifecycle_safe_mode_tracker_top verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

### files.f
rtl/fltrk_pkg.sv
rtl/fltrk_if.sv
rtl/fault_lifecycle_safe_mode_tracker_top.sv
sim/fltrk_outcome_checker.sv
sim/fault_lifecycle_safe_mode_tracker_top_tb.sv
